// File: rtl/bsdu_pkg.sv
`default_nettype none
package bsdu_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int ADDR_W = 16;
	localparam int STEP_W = 16;
	localparam int DEPTH_W = 8;
	localparam int HITS_W = 32;
	localparam int ACT_W = 4;
	localparam int MODE_W = 3;
	localparam int SLOT_W = 4;

	localparam logic [ACT_W-1:0] ACT_CHECK     = 4'd0;
	localparam logic [ACT_W-1:0] ACT_ADD       = 4'd1;
	localparam logic [ACT_W-1:0] ACT_REMOVE    = 4'd2;
	localparam logic [ACT_W-1:0] ACT_ENABLE    = 4'd3;
	localparam logic [ACT_W-1:0] ACT_DISABLE   = 4'd4;
	localparam logic [ACT_W-1:0] ACT_RUN       = 4'd5;
	localparam logic [ACT_W-1:0] ACT_CONTINUE  = 4'd6;
	localparam logic [ACT_W-1:0] ACT_STEP_IN   = 4'd7;
	localparam logic [ACT_W-1:0] ACT_STEP_OVER = 4'd8;
	localparam logic [ACT_W-1:0] ACT_STEP_OUT  = 4'd9;
	localparam logic [ACT_W-1:0] ACT_STOP      = 4'd10;
	localparam logic [ACT_W-1:0] ACT_RESET     = 4'd11;

	localparam logic [MODE_W-1:0] MODE_RUN       = 3'd0;
	localparam logic [MODE_W-1:0] MODE_STEP_IN   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_STEP_OVER = 3'd2;
	localparam logic [MODE_W-1:0] MODE_STEP_OUT  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_BREAK     = 3'd4;

	typedef struct packed {
		logic [ACT_W-1:0]   action;
		logic [ADDR_W-1:0]  bp_address;
		logic [STEP_W-1:0]  step_count;
		logic [ADDR_W-1:0]  cur_pc;
		logic               machine_halted;
		logic [DEPTH_W-1:0] call_depth;
	} item_t;

	typedef struct packed {
		logic               stop;
		logic               bp_hit;
		logic [SLOT_W-1:0]  slot;
		logic               failed;
		logic [MODE_W-1:0]  mode_now;
	} result_t;

	typedef struct packed {
		logic load;
		logic apply;
	} cmd_t;

endpackage
`default_nettype wire

// File: rtl/bsdu_if.sv
`default_nettype none
interface bsdu_in_if;
	logic                          valid;
	logic                          ready;
	logic [bsdu_pkg::ACT_W-1:0]    action;
	logic [bsdu_pkg::ADDR_W-1:0]   bp_address;
	logic [bsdu_pkg::STEP_W-1:0]   step_count;
	logic [bsdu_pkg::ADDR_W-1:0]   cur_pc;
	logic                          machine_halted;
	logic [bsdu_pkg::DEPTH_W-1:0]  call_depth;

	modport source(output valid, action, bp_address, step_count, cur_pc, machine_halted,
		call_depth, input ready);
	modport sink(input valid, action, bp_address, step_count, cur_pc, machine_halted,
		call_depth, output ready);
endinterface

interface bsdu_out_if;
	logic                          valid;
	logic                          ready;
	logic                          stop;
	logic                          bp_hit;
	logic [bsdu_pkg::SLOT_W-1:0]   slot;
	logic                          failed;
	logic [bsdu_pkg::MODE_W-1:0]   mode_now;

	modport source(output valid, stop, bp_hit, slot, failed, mode_now, input ready);
	modport sink(input valid, stop, bp_hit, slot, failed, mode_now, output ready);
endinterface
`default_nettype wire

// File: rtl/bsdu_ctrl.sv
`default_nettype none
module bsdu_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output bsdu_pkg::cmd_t       cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_APPLY
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load  = in_valid && (state_q == ST_IDLE);
		cmd.apply = (state_q == ST_APPLY) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_APPLY && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_MATCH;
				end
				ST_MATCH: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					// wait until the result register can take the item
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/bsdu_dp.sv
`default_nettype none
module bsdu_dp (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bsdu_pkg::cmd_t   cmd,
	input  wire bsdu_pkg::item_t  item,
	output bsdu_pkg::result_t     result
);

	localparam int N = bsdu_pkg::MAX_ENTRIES;

	bsdu_pkg::item_t                  item_q;
	bsdu_pkg::result_t                result_q;
	logic [N-1:0]                     match_s2;

	logic [bsdu_pkg::ADDR_W-1:0]      addr_q [N];
	logic [N-1:0]                     en_q;
	logic [bsdu_pkg::HITS_W-1:0]      hits_q [N];
	logic [bsdu_pkg::CNT_W-1:0]       count_q;

	logic                             run_q;
	logic [bsdu_pkg::MODE_W-1:0]      mode_q;
	logic [bsdu_pkg::STEP_W-1:0]      steps_q;
	logic [bsdu_pkg::DEPTH_W-1:0]     tdepth_q;

	logic [bsdu_pkg::ADDR_W-1:0]      key;
	logic                             is_check;
	logic                             any;
	logic [bsdu_pkg::IDX_W-1:0]       idx;
	logic [bsdu_pkg::STEP_W-1:0]      steps_dec;
	logic                             full;

	logic                             run_n;
	logic [bsdu_pkg::MODE_W-1:0]      mode_n;
	logic [bsdu_pkg::STEP_W-1:0]      steps_n;
	logic [bsdu_pkg::DEPTH_W-1:0]     tdepth_n;
	bsdu_pkg::result_t                res_n;

	assign is_check = (item_q.action == bsdu_pkg::ACT_CHECK);
	assign key      = is_check ? item_q.cur_pc : item_q.bp_address;
	assign full     = (count_q >= bsdu_pkg::CNT_W'(N));

	// compare stage: one lane per table entry, live entries only
	always_ff @(posedge clk) begin
		for (int i = 0; i < N; i++) begin
			match_s2[i] <= (bsdu_pkg::CNT_W'(i) < count_q) && (addr_q[i] == key)
				&& (en_q[i] || !is_check);
		end
	end

	// lowest matching index wins
	always_comb begin
		any = |match_s2;
		idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (match_s2[i])
				idx = bsdu_pkg::IDX_W'(i);
		end
	end

	assign steps_dec = (steps_q == '0) ? '0 : steps_q - 1'b1;

	always_comb begin
		run_n    = run_q;
		mode_n   = mode_q;
		steps_n  = steps_q;
		tdepth_n = tdepth_q;
		res_n    = '0;
		unique case (item_q.action)
			bsdu_pkg::ACT_CHECK: begin
				priority if (!run_q || item_q.machine_halted) begin
					res_n.stop = 1'b1;
				end else if (any) begin
					res_n.stop   = 1'b1;
					res_n.bp_hit = 1'b1;
					res_n.slot   = bsdu_pkg::SLOT_W'(idx);
					mode_n       = bsdu_pkg::MODE_BREAK;
				end else if (mode_q == bsdu_pkg::MODE_STEP_IN) begin
					steps_n = steps_dec;
					if (steps_dec == '0) begin
						res_n.stop = 1'b1;
						mode_n     = bsdu_pkg::MODE_BREAK;
					end
				end else if (mode_q == bsdu_pkg::MODE_STEP_OVER) begin
					// a step only counts once back at or above the target frame
					if (item_q.call_depth <= tdepth_q) begin
						steps_n = steps_dec;
						if (steps_dec == '0) begin
							res_n.stop = 1'b1;
							mode_n     = bsdu_pkg::MODE_BREAK;
						end
					end
				end else if (mode_q == bsdu_pkg::MODE_STEP_OUT) begin
					if (item_q.call_depth < tdepth_q) begin
						res_n.stop = 1'b1;
						mode_n     = bsdu_pkg::MODE_BREAK;
					end
				end else begin
					res_n.stop = 1'b0;
				end
			end
			bsdu_pkg::ACT_ADD: begin
				if (full)
					res_n.failed = 1'b1;
				else if (any)
					res_n.slot = bsdu_pkg::SLOT_W'(idx);
				else
					res_n.slot = bsdu_pkg::SLOT_W'(count_q);
			end
			bsdu_pkg::ACT_REMOVE, bsdu_pkg::ACT_ENABLE, bsdu_pkg::ACT_DISABLE: begin
				res_n.failed = !any;
			end
			bsdu_pkg::ACT_RUN: begin
				mode_n = bsdu_pkg::MODE_RUN;
				run_n  = 1'b1;
			end
			bsdu_pkg::ACT_CONTINUE: begin
				mode_n  = bsdu_pkg::MODE_RUN;
				run_n   = 1'b1;
				steps_n = '0;
			end
			bsdu_pkg::ACT_STEP_IN: begin
				mode_n  = bsdu_pkg::MODE_STEP_IN;
				run_n   = 1'b1;
				steps_n = item_q.step_count;
			end
			bsdu_pkg::ACT_STEP_OVER: begin
				mode_n   = bsdu_pkg::MODE_STEP_OVER;
				run_n    = 1'b1;
				steps_n  = item_q.step_count;
				tdepth_n = item_q.call_depth;
			end
			bsdu_pkg::ACT_STEP_OUT: begin
				mode_n = bsdu_pkg::MODE_STEP_OUT;
				run_n  = 1'b1;
			end
			bsdu_pkg::ACT_STOP: begin
				mode_n = bsdu_pkg::MODE_BREAK;
				run_n  = 1'b0;
			end
			bsdu_pkg::ACT_RESET: begin
				mode_n  = bsdu_pkg::MODE_RUN;
				run_n   = 1'b1;
				steps_n = '0;
			end
			default: begin
				res_n = '0;
			end
		endcase
		res_n.mode_now = mode_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b1;
			mode_q   <= bsdu_pkg::MODE_RUN;
			steps_q  <= '0;
			tdepth_q <= '0;
			count_q  <= '0;
		end else if (cmd.apply) begin
			run_q    <= run_n;
			mode_q   <= mode_n;
			steps_q  <= steps_n;
			tdepth_q <= tdepth_n;
			if (item_q.action == bsdu_pkg::ACT_ADD && !full && !any)
				count_q <= count_q + 1'b1;
			else if (item_q.action == bsdu_pkg::ACT_REMOVE && any)
				count_q <= count_q - 1'b1;
			else if (item_q.action == bsdu_pkg::ACT_RESET)
				count_q <= '0;
		end
	end

	// table storage and payload registers
	always_ff @(posedge clk) begin
		if (cmd.load)
			item_q <= item;
		if (cmd.apply) begin
			result_q <= res_n;
			if (is_check && run_q && !item_q.machine_halted && any) begin
				if (hits_q[idx] != '1)
					hits_q[idx] <= hits_q[idx] + 1'b1;
			end
			if (item_q.action == bsdu_pkg::ACT_ADD && !full) begin
				if (any) begin
					en_q[idx] <= 1'b1;
				end else begin
					addr_q[count_q[bsdu_pkg::IDX_W-1:0]] <= key;
					en_q[count_q[bsdu_pkg::IDX_W-1:0]]   <= 1'b1;
					hits_q[count_q[bsdu_pkg::IDX_W-1:0]] <= '0;
				end
			end
			if (item_q.action == bsdu_pkg::ACT_REMOVE && any) begin
				// close the gap: every entry above the removed one moves down
				for (int i = 0; i < N - 1; i++) begin
					if (bsdu_pkg::IDX_W'(i) >= idx) begin
						addr_q[i] <= addr_q[i+1];
						en_q[i]   <= en_q[i+1];
						hits_q[i] <= hits_q[i+1];
					end
				end
			end
			if ((item_q.action == bsdu_pkg::ACT_ENABLE ||
				item_q.action == bsdu_pkg::ACT_DISABLE) && any)
				en_q[idx] <= (item_q.action == bsdu_pkg::ACT_ENABLE);
		end
	end

	assign result = result_q;

endmodule
`default_nettype wire

// File: rtl/breakpoint_step_debug_unit.sv
`default_nettype none
// Breakpoint and step debug unit. Each item on in_ch is either a check for the instruction
// at cur_pc or a command that edits the 16-entry breakpoint table or sets the run/step mode;
// each item gives exactly one result on out_ch. The result is registered in the apply state:
// the item is registered as it is accepted, the match state registers the parallel address
// compare over all table entries, and the apply state picks the first match and updates
// table and mode. Removal closes the gap in that same update cycle. The next item is taken
// only once the previous one has reached the result register, so items never overlap;
// a held result delays the update cycle of the following item.
module breakpoint_step_debug_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	bsdu_in_if.sink     in_ch,
	bsdu_out_if.source  out_ch
);

	bsdu_pkg::cmd_t    cmd;
	bsdu_pkg::item_t   item;
	bsdu_pkg::result_t result;

	always_comb begin
		item.action         = in_ch.action;
		item.bp_address     = in_ch.bp_address;
		item.step_count     = in_ch.step_count;
		item.cur_pc         = in_ch.cur_pc;
		item.machine_halted = in_ch.machine_halted;
		item.call_depth     = in_ch.call_depth;
	end

	bsdu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	bsdu_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.result (result)
	);

	assign out_ch.stop     = result.stop;
	assign out_ch.bp_hit   = result.bp_hit;
	assign out_ch.slot     = result.slot;
	assign out_ch.failed   = result.failed;
	assign out_ch.mode_now = result.mode_now;

endmodule
`default_nettype wire
